// File: src/ddam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ddam_pkg;

    localparam int NumDigitsDefault = 32;
    localparam int DigitW           = 4;
    localparam int PosW             = 6;
    localparam int CarryW           = 5;
    localparam int ProdW            = 8;
    localparam int Radix            = 10;

    typedef enum logic [2:0] {
        S_LOAD,
        S_ROW,
        S_ROWB,
        S_COL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              func;
        logic [DigitW-1:0] digit_a;
        logic [DigitW-1:0] digit_b;
        logic              last_digit;
    } t_in_beat;

    typedef struct packed {
        logic [DigitW-1:0] result_digit;
        logic [PosW-1:0]   digit_position;
        logic              overflow;
        logic              last_result;
    } t_out_beat;

    // quotient by ten through the reciprocal 205/2048, exact below 1029
    function automatic logic [CarryW-1:0] div10(input logic [ProdW-1:0] x);
        logic [15:0] p;
        p = 16'(x) * 16'd205;
        return CarryW'(p >> 11);
    endfunction

endpackage

`default_nettype wire

// File: src/ddam_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface ddam_in_if;
    import ddam_pkg::*;
    logic     valid;
    logic     ready;
    t_in_beat payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ddam_out_if;
    import ddam_pkg::*;
    logic      valid;
    logic      ready;
    t_out_beat payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: src/ddam_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ddam_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: src/decimal_digit_add_multiply_top.sv
// load: one digit pair per cycle, NUM_DIGITS pairs at most
// add: two passes over all NUM_DIGITS columns; multiply: one row per multiplier digit j over NUM_DIGITS - j columns,
//   one digit product per cycle in the shared unit while a row's columns are swept, after its S_ROW and S_ROWB states
// result: NUM_DIGITS beats, each a registered accumulator read; no read issues while one is pending
// one number pair at a time: no new beat is taken until the last result beat leaves
// synchronous active-low reset clears the sequencer and fill counts; stores need no clearing
`timescale 1ns / 1ps
`default_nettype none

module decimal_digit_add_multiply_top
    import ddam_pkg::*;
#(
    parameter int NUM_DIGITS = NumDigitsDefault
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    ddam_in_if.sink   i_in,
    ddam_out_if.source o_out
);

    localparam int AW = $clog2(NUM_DIGITS);
    localparam int CW = AW + 1;

    t_state r_state, n_state;

    logic [CW-1:0]     r_load_cnt, n_load_cnt;
    logic [CW-1:0]     r_a_len, n_a_len;
    logic [CW-1:0]     r_b_len, n_b_len;
    logic              r_func, n_func;
    logic [AW-1:0]     r_row, n_row;
    logic [AW-1:0]     r_col, n_col;
    logic [AW-1:0]     r_acol, n_acol;
    logic [CarryW-1:0] r_mc, n_mc;
    logic              r_ac, n_ac;
    logic [DigitW-1:0] r_mult, n_mult;
    logic              r_mval, n_mval;
    logic              r_bval, n_bval;
    logic              r_ovf, n_ovf;
    logic [AW-1:0]     r_rk, n_rk;
    logic              r_rd_all, n_rd_all;
    logic              r_pend, n_pend;
    logic [AW-1:0]     r_pend_pos, n_pend_pos;
    logic              r_out_valid, n_out_valid;
    t_out_beat         r_out, n_out;

    logic              ab_we;
    logic              acc_we;
    logic [AW-1:0]     a_raddr, b_raddr, acc_raddr;
    logic [DigitW-1:0] a_rdata, b_rdata, acc_rdata;
    logic [DigitW-1:0] acc_wdata;

    logic              row_last, src_b, col_end, drop_hi, issue;
    logic [AW-1:0]     shift, col_nxt, acol_nxt;
    logic [CW-1:0]     src_len;
    logic [DigitW-1:0] m_dig, acc_old, d_dig;
    logic [ProdW-1:0]  prod, rem;
    logic [CarryW-1:0] q;
    logic [CarryW-1:0] sum;
    logic              ac_n;

    ddam_ram #(.WIDTH(DigitW), .DEPTH(NUM_DIGITS)) u_a_ram (
        .i_clk   (i_clk),
        .i_we    (ab_we),
        .i_waddr (r_load_cnt[AW-1:0]),
        .i_wdata (i_in.payload.digit_a),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    ddam_ram #(.WIDTH(DigitW), .DEPTH(NUM_DIGITS)) u_b_ram (
        .i_clk   (i_clk),
        .i_we    (ab_we),
        .i_waddr (r_load_cnt[AW-1:0]),
        .i_wdata (i_in.payload.digit_b),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    ddam_ram #(.WIDTH(DigitW), .DEPTH(NUM_DIGITS)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (r_acol),
        .i_wdata (acc_wdata),
        .i_raddr (acc_raddr),
        .o_rdata (acc_rdata)
    );

    // addition runs as two passes with multiplier one: acc = A, then acc += B
    always_comb begin
        row_last = r_func ? (r_row == AW'(NUM_DIGITS - 1)) : (r_row == AW'(1));
        shift    = r_func ? r_row : '0;
        src_b    = !r_func && (r_row != '0);
        src_len  = src_b ? r_b_len : r_a_len;
        col_nxt  = (r_state == S_ROWB) ? '0 : r_col + AW'(1);
        acol_nxt = (r_state == S_ROWB) ? shift : r_acol + AW'(1);
        col_end  = (r_acol == AW'(NUM_DIGITS - 1));

        a_raddr   = col_nxt;
        b_raddr   = (r_state == S_ROW) ? r_row : col_nxt;
        acc_raddr = (r_state == S_OUT) ? r_rk : acol_nxt;

        // digits past the fill count read as zero
        n_mval = ({1'b0, col_nxt} < r_load_cnt);
        n_bval = ({1'b0, r_row} < r_load_cnt);

        m_dig   = r_mval ? (src_b ? b_rdata : a_rdata) : '0;
        prod    = ProdW'(m_dig) * ProdW'(r_mult) + ProdW'(r_mc);
        q       = div10(prod);
        rem     = prod - ProdW'(q) * ProdW'(Radix);
        d_dig   = rem[DigitW-1:0];
        acc_old = (r_row == '0) ? '0 : acc_rdata;
        sum     = CarryW'(acc_old) + CarryW'(d_dig) + CarryW'(r_ac);
        ac_n    = (sum >= CarryW'(Radix));
        acc_wdata = ac_n ? DigitW'(sum - CarryW'(Radix)) : sum[DigitW-1:0];

        // multiplicand digits that shift past the top digit
        drop_hi = (r_mult != '0) && (src_len > (CW'(NUM_DIGITS) - {1'b0, shift}));

        issue = !r_pend && !r_rd_all && (!r_out_valid || o_out.ready);
    end

    always_comb begin
        n_state     = r_state;
        n_load_cnt  = r_load_cnt;
        n_a_len     = r_a_len;
        n_b_len     = r_b_len;
        n_func      = r_func;
        n_row       = r_row;
        n_col       = r_col;
        n_acol      = r_acol;
        n_mc        = r_mc;
        n_ac        = r_ac;
        n_mult      = r_mult;
        n_ovf       = r_ovf;
        n_rk        = r_rk;
        n_rd_all    = r_rd_all;
        n_pend      = r_pend;
        n_pend_pos  = r_pend_pos;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ab_we       = 1'b0;
        acc_we      = 1'b0;
        i_in.ready  = 1'b0;

        case (r_state)
            S_LOAD: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    if (r_load_cnt < CW'(NUM_DIGITS)) begin
                        ab_we      = 1'b1;
                        n_load_cnt = r_load_cnt + CW'(1);
                        if (i_in.payload.digit_a != '0) begin
                            n_a_len = r_load_cnt + CW'(1);
                        end
                        if (i_in.payload.digit_b != '0) begin
                            n_b_len = r_load_cnt + CW'(1);
                        end
                    end
                    if (i_in.payload.last_digit) begin
                        n_func  = i_in.payload.func;
                        n_row   = '0;
                        n_ovf   = 1'b0;
                        n_state = S_ROW;
                    end
                end
            end
            S_ROW: begin
                n_state = S_ROWB;
            end
            S_ROWB: begin
                n_mult  = r_func ? (r_bval ? b_rdata : '0) : DigitW'(1);
                n_col   = col_nxt;
                n_acol  = acol_nxt;
                n_mc    = '0;
                n_ac    = 1'b0;
                n_state = S_COL;
            end
            S_COL: begin
                acc_we = 1'b1;
                n_mc   = q;
                n_ac   = ac_n;
                if (col_end) begin
                    n_ovf = r_ovf || (q != '0) || ac_n || drop_hi;
                    if (row_last) begin
                        n_load_cnt = '0;
                        n_a_len    = '0;
                        n_b_len    = '0;
                        n_rk       = '0;
                        n_rd_all   = 1'b0;
                        n_pend     = 1'b0;
                        n_state    = S_OUT;
                    end else begin
                        n_row   = r_row + AW'(1);
                        n_state = S_ROW;
                    end
                end else begin
                    n_col  = col_nxt;
                    n_acol = acol_nxt;
                end
            end
            S_OUT: begin
                if (issue) begin
                    n_pend     = 1'b1;
                    n_pend_pos = r_rk;
                    n_rk       = r_rk + AW'(1);
                    if (r_rk == AW'(NUM_DIGITS - 1)) begin
                        n_rd_all = 1'b1;
                    end
                end
                if (r_pend) begin
                    // output register is free here: it was empty or taken at issue
                    n_pend                 = 1'b0;
                    n_out_valid            = 1'b1;
                    n_out.result_digit     = acc_rdata;
                    n_out.digit_position   = PosW'(r_pend_pos);
                    n_out.last_result      = (r_pend_pos == AW'(NUM_DIGITS - 1));
                    n_out.overflow         = (r_pend_pos == AW'(NUM_DIGITS - 1)) && r_ovf;
                end else if (r_out_valid && o_out.ready) begin
                    n_out_valid = 1'b0;
                    if (r_out.last_result) begin
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_load_cnt  <= '0;
            r_a_len     <= '0;
            r_b_len     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_rd_all    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load_cnt  <= n_load_cnt;
            r_a_len     <= n_a_len;
            r_b_len     <= n_b_len;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            r_rd_all    <= n_rd_all;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_row      <= n_row;
        r_col      <= n_col;
        r_acol     <= n_acol;
        r_mc       <= n_mc;
        r_ac       <= n_ac;
        r_mult     <= n_mult;
        r_mval     <= n_mval;
        r_bval     <= n_bval;
        r_ovf      <= n_ovf;
        r_rk       <= n_rk;
        r_pend_pos <= n_pend_pos;
        r_out      <= n_out;
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    a_out_in_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_state == S_OUT))
        else $error("result beat outside output phase");

    a_ovf_only_on_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.overflow) |-> o_out.payload.last_result)
        else $error("overflow flag on a digit below the top");

    a_acc_digit_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COL) |-> (acc_wdata < DigitW'(Radix)))
        else $error("accumulator digit out of decimal range");

    a_col_tracks_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COL) |-> (r_acol == r_col + shift))
        else $error("accumulator column out of step with row shift");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_load_cnt <= CW'(NUM_DIGITS)) && (r_a_len <= r_load_cnt) && (r_b_len <= r_load_cnt))
        else $error("fill count past store depth");

endmodule

`default_nettype wire
